// File: rtl/bm_pkg.sv
package bm_pkg;

   localparam int MAX_SAMPLES_DEF = 64;
   localparam int DATA_W          = 16;
   localparam int COUNT_OUT_W     = 7;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              last_sample;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]      median;
      logic [COUNT_OUT_W-1:0] sample_count;
      logic                   dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_PLACE,
      ST_MED_RD,
      ST_MED_A,
      ST_MED_B
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_OVERFLOW,
      OP_SCAN,
      OP_SHIFT,
      OP_PLACE,
      OP_MED_RD,
      OP_MED_LO,
      OP_EMIT_ODD,
      OP_EMIT_EVEN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last;
      logic greater;
      logic pos_one;
      logic odd;
   } status_type;

endpackage

// File: rtl/block_median.sv
// Channel        Ports                          Direction  Handshake
// request        start, busy, req_item          in         taken when start and not busy
// response       rsp_valid, rsp_item            out        one-cycle strobe, never held off
//
// Each transaction inserts its sample into an ascending store in a registered-read RAM;
// a sample into a full store is dropped and sets the drop flag. Busy covers the check,
// the shift of each stored entry larger than the sample, and the placing. A closing
// sample adds the median read-out; the result strobe comes in the first cycle after busy.
// Reset clears the count, the drop flag and the strobe; the RAM is never cleared, as only
// entries below the count are read. The receiver cannot stall, so results never wait.
module block_median #(
   parameter int MAX_SAMPLES = bm_pkg::MAX_SAMPLES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  bm_pkg::req_type req_item,
   output logic            rsp_valid,
   output bm_pkg::rsp_type rsp_item
);

   // Commands travel from the controller to the datapath, and the status
   // flags (full, empty, last, greater, position one, count parity)
   // travel back; nothing else joins the two halves.
   bm_pkg::cmd_type    cmd;
   bm_pkg::status_type status;

   // The controller sequences capture, the insertion scan, and the median
   // read-out of one transaction at a time.
   bm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the sorted store, the count, the drop flag and the
   // registered result.
   bm_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/bm_ram.sv
module bm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/bm_ctrl.sv
module bm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bm_pkg::status_type status,
   output bm_pkg::cmd_type    cmd,
   output logic               busy
);

   bm_pkg::state_type state_ff;
   bm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bm_pkg::ST_CHECK;
            end
         end
         bm_pkg::ST_CHECK: begin
            if (status.full) begin
               state_in = status.last ? bm_pkg::ST_MED_RD : bm_pkg::ST_IDLE;
            end else if (status.empty) begin
               state_in = status.last ? bm_pkg::ST_MED_RD : bm_pkg::ST_IDLE;
            end else begin
               state_in = bm_pkg::ST_SHIFT;
            end
         end
         bm_pkg::ST_SHIFT: begin
            if (status.greater) begin
               state_in = status.pos_one ? bm_pkg::ST_PLACE : bm_pkg::ST_SHIFT;
            end else begin
               state_in = status.last ? bm_pkg::ST_MED_RD : bm_pkg::ST_IDLE;
            end
         end
         bm_pkg::ST_PLACE: begin
            state_in = status.last ? bm_pkg::ST_MED_RD : bm_pkg::ST_IDLE;
         end
         bm_pkg::ST_MED_RD: begin
            state_in = bm_pkg::ST_MED_A;
         end
         bm_pkg::ST_MED_A: begin
            state_in = status.odd ? bm_pkg::ST_IDLE : bm_pkg::ST_MED_B;
         end
         bm_pkg::ST_MED_B: begin
            state_in = bm_pkg::ST_IDLE;
         end
         default: begin
            state_in = bm_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op = bm_pkg::OP_NONE;
      case (state_ff)
         bm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op = bm_pkg::OP_CAPTURE;
            end
         end
         bm_pkg::ST_CHECK: begin
            if (status.full) begin
               cmd.op = bm_pkg::OP_OVERFLOW;
            end else if (status.empty) begin
               cmd.op = bm_pkg::OP_PLACE;
            end else begin
               cmd.op = bm_pkg::OP_SCAN;
            end
         end
         bm_pkg::ST_SHIFT: begin
            cmd.op = status.greater ? bm_pkg::OP_SHIFT : bm_pkg::OP_PLACE;
         end
         bm_pkg::ST_PLACE: begin
            cmd.op = bm_pkg::OP_PLACE;
         end
         bm_pkg::ST_MED_RD: begin
            cmd.op = bm_pkg::OP_MED_RD;
         end
         bm_pkg::ST_MED_A: begin
            cmd.op = status.odd ? bm_pkg::OP_EMIT_ODD : bm_pkg::OP_MED_LO;
         end
         bm_pkg::ST_MED_B: begin
            cmd.op = bm_pkg::OP_EMIT_EVEN;
         end
         default: begin
            cmd.op = bm_pkg::OP_NONE;
         end
      endcase
   end

   assign busy = (state_ff != bm_pkg::ST_IDLE);

endmodule

// File: rtl/bm_dp.sv
module bm_dp #(
   parameter int MAX_SAMPLES = bm_pkg::MAX_SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bm_pkg::req_type    req_item,
   input  bm_pkg::cmd_type    cmd,
   output bm_pkg::status_type status,
   output logic               rsp_valid,
   output bm_pkg::rsp_type    rsp_item
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   logic [bm_pkg::DATA_W-1:0] sample_ff, sample_in;
   logic                      last_ff, last_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      overflow_ff, overflow_in;
   logic [bm_pkg::DATA_W-1:0] lo_ff, lo_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bm_pkg::rsp_type           rsp_item_ff, rsp_item_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [bm_pkg::DATA_W-1:0] wr_data;
   logic [AW-1:0]             rd_addr;
   logic [bm_pkg::DATA_W-1:0] rd_data;
   logic [CNT_W-1:0]          half;
   logic [AW-1:0]             half_idx;
   logic [bm_pkg::DATA_W:0]   pair_sum;

   assign half     = count_ff >> 1;
   assign half_idx = half[AW-1:0];
   assign pair_sum = {1'b0, lo_ff} + {1'b0, rd_data};

   bm_ram #(
      .WIDTH (bm_pkg::DATA_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Store addressing.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = sample_ff;
      rd_addr = pos_ff - AW'(1);
      case (cmd.op)
         bm_pkg::OP_SCAN: begin
            rd_addr = pos_ff - AW'(1);
         end
         bm_pkg::OP_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            rd_addr = pos_ff - AW'(2);
         end
         bm_pkg::OP_PLACE: begin
            wr_en = 1'b1;
         end
         bm_pkg::OP_MED_RD: begin
            rd_addr = count_ff[0] ? half_idx : half_idx - AW'(1);
         end
         bm_pkg::OP_MED_LO: begin
            rd_addr = half_idx;
         end
         default: begin
            rd_addr = pos_ff - AW'(1);
         end
      endcase
   end

   // Register updates.
   always_comb begin
      sample_in    = sample_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      lo_in        = lo_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      case (cmd.op)
         bm_pkg::OP_CAPTURE: begin
            sample_in = req_item.sample;
            last_in   = req_item.last_sample;
            pos_in    = count_ff[AW-1:0];
         end
         bm_pkg::OP_OVERFLOW: begin
            overflow_in = 1'b1;
         end
         bm_pkg::OP_SHIFT: begin
            pos_in = pos_ff - AW'(1);
         end
         bm_pkg::OP_PLACE: begin
            count_in = count_ff + CNT_W'(1);
         end
         bm_pkg::OP_MED_LO: begin
            lo_in = rd_data;
         end
         bm_pkg::OP_EMIT_ODD, bm_pkg::OP_EMIT_EVEN: begin
            rsp_valid_in             = 1'b1;
            rsp_item_in.median       = (cmd.op == bm_pkg::OP_EMIT_ODD) ?
                                       rd_data : pair_sum[bm_pkg::DATA_W:1];
            rsp_item_in.sample_count = bm_pkg::COUNT_OUT_W'(count_ff);
            rsp_item_in.dropped      = overflow_ff;
            count_in                 = '0;
            overflow_in              = 1'b0;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign status.full    = (count_ff == CNT_W'(MAX_SAMPLES));
   assign status.empty   = (count_ff == '0);
   assign status.last    = last_ff;
   assign status.greater = (rd_data > sample_ff);
   assign status.pos_one = (pos_ff == AW'(1));
   assign status.odd     = count_ff[0];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("stored count exceeds capacity");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff == '0) && !overflow_ff)
      else $error("store not cleared when the median was issued");

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bm_pkg::OP_PLACE) |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("placing a sample did not advance the count");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bm_pkg::OP_EMIT_ODD || cmd.op == bm_pkg::OP_EMIT_EVEN) |->
      (count_ff != '0))
      else $error("median taken over an empty store");

endmodule
